[hw/rtl/arm64_xref_detector_defines.svh]
// Assertion macros shared by the cross-reference detector RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ARM64_XREF_DETECTOR_DEFINES_SVH
`define ARM64_XREF_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AXD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AXD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/axd_pkg.sv]
// Types, codes and constants of the cross-reference detector.
// Depends on nothing; imported by every module of the block.
package axd_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int PAGE_W    = 52;
    localparam int OFFSET_W  = 24;

    // Register indexes of the configuration port.
    localparam logic CFG_SECTION_START = 1'b0;
    localparam logic CFG_SECTION_LIMIT = 1'b1;

    // Opcode fields and match patterns.
    localparam logic [5:0]  OP_BL        = 6'h25;
    localparam logic [5:0]  OP_B         = 6'h05;
    localparam logic [7:0]  OP_BCOND     = 8'h54;
    localparam logic [31:0] MASK_CB      = 32'h7E00_0000;
    localparam logic [31:0] PAT_CBZ      = 32'h3400_0000;
    localparam logic [31:0] PAT_TBZ      = 32'h3600_0000;
    localparam logic [31:0] MASK_ADRP    = 32'h9F00_0000;
    localparam logic [31:0] PAT_ADRP     = 32'h9000_0000;
    localparam logic [31:0] MASK_ADD     = 32'h7F80_0000;
    localparam logic [31:0] PAT_ADD      = 32'h1100_0000;
    localparam logic [31:0] MASK_LDR     = 32'hBFC0_0000;
    localparam logic [31:0] PAT_LDR      = 32'hB940_0000;

    typedef enum logic [1:0] {
        KIND_CALL   = 2'd0,
        KIND_BRANCH = 2'd1,
        KIND_DATA   = 2'd2
    } kind_t;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [PAGE_W-1:0]    page_t;

    typedef struct packed {
        logic [63:0] insn_address;
        logic [31:0] insn_word;
        logic        first_of_run;
    } insn_t;

    typedef struct packed {
        logic [63:0] source_address;
        logic [63:0] target_address;
        kind_t       ref_kind;
    } xref_t;

    // Decoded view of one instruction word.
    typedef struct packed {
        logic                is_call;
        logic                is_branch;
        logic                is_adrp;
        logic                is_mem;
        reg_idx_t            rd;
        reg_idx_t            rn;
        logic [63:0]         branch_target;
        page_t               mark_page;
        logic [OFFSET_W-1:0] data_offset;
    } dec_t;

    // Page table operations for one accepted word.
    typedef struct packed {
        logic     clear_all;
        logic     set_en;
        reg_idx_t set_idx;
        page_t    set_page;
        logic     use_en;
        reg_idx_t use_idx;
    } pt_ctl_t;

endpackage

[hw/rtl/axd_decode.sv]
// Instruction decoder: classifies one word and forms branch targets, ADRP pages
// and data offsets. Depends on axd_pkg.
module axd_decode
    import axd_pkg::*;
(
    input  insn_t insn,
    output dec_t  dec
);

    logic [31:0] w;
    logic [63:0] pc;
    logic [63:0] off_26;
    logic [63:0] off_19;
    logic [63:0] off_14;
    page_t       page_delta;
    logic [11:0] imm12;

    assign w  = insn.insn_word;
    assign pc = insn.insn_address;

    assign off_26     = {{36{w[25]}}, w[25:0], 2'b00};
    assign off_19     = {{43{w[23]}}, w[23:5], 2'b00};
    assign off_14     = {{48{w[18]}}, w[18:5], 2'b00};
    assign page_delta = {{31{w[23]}}, w[23:5], w[30:29]};
    assign imm12      = w[21:10];

    always_comb
    begin
        dec               = '0;
        dec.rd            = w[4:0];
        dec.rn            = w[9:5];
        dec.mark_page     = pc[63:12] + page_delta;
        dec.branch_target = pc + off_19;
        if ((w & MASK_ADD) == PAT_ADD)
        begin
            dec.data_offset = w[22] ? {imm12, 12'h000} : {12'h000, imm12};
        end
        else
        begin
            dec.data_offset = {12'h000, imm12} << {1'b1, w[30]};
        end

        // Earlier tests take precedence, as in the instruction classes below.
        priority if (w[31:26] == OP_BL)
        begin
            dec.is_call       = 1'b1;
            dec.branch_target = pc + off_26;
        end
        else if (w[31:26] == OP_B)
        begin
            dec.is_branch     = 1'b1;
            dec.branch_target = pc + off_26;
        end
        else if (w[31:24] == OP_BCOND && !w[4])
        begin
            dec.is_branch = 1'b1;
        end
        else if ((w & MASK_CB) == PAT_CBZ)
        begin
            dec.is_branch = 1'b1;
        end
        else if ((w & MASK_CB) == PAT_TBZ)
        begin
            dec.is_branch     = 1'b1;
            dec.branch_target = pc + off_14;
        end
        else if ((w & MASK_ADRP) == PAT_ADRP)
        begin
            dec.is_adrp = 1'b1;
        end
        else if ((w & MASK_ADD) == PAT_ADD || (w & MASK_LDR) == PAT_LDR)
        begin
            dec.is_mem = 1'b1;
        end
        else
        begin
            dec.is_mem = 1'b0;
        end
    end

endmodule

[hw/rtl/axd_page_table.sv]
// Per-register ADRP page store (synchronous memory) and pending marks.
// Depends on axd_pkg.
module axd_page_table
    import axd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pt_ctl_t              ctl,
    output logic [REG_COUNT-1:0] pending,
    output page_t                read_page
);

    page_t                mem [REG_COUNT];
    page_t                read_page_reg;
    logic [REG_COUNT-1:0] pending_reg;
    logic [REG_COUNT-1:0] pending_next;

    // A page is written when its ADRP is accepted and read when a consumer is
    // accepted, so a later word always sees the stored page.
    always_ff @(posedge clk)
    begin
        if (ctl.set_en)
        begin
            mem[ctl.set_idx] <= ctl.set_page;
        end
        if (ctl.use_en)
        begin
            read_page_reg <= mem[ctl.use_idx];
        end
    end

    always_comb
    begin
        pending_next = ctl.clear_all ? '0 : pending_reg;
        if (ctl.set_en)
        begin
            pending_next[ctl.set_idx] = 1'b1;
        end
        if (ctl.use_en)
        begin
            pending_next[ctl.use_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    assign pending   = pending_reg;
    assign read_page = read_page_reg;

endmodule

[hw/rtl/arm64_xref_detector.sv]
// Top level of the ARM64 cross-reference detector: handshakes, pipeline and
// section filter. Depends on axd_pkg, axd_decode, axd_page_table and the defines header.
//
//  Channel   Direction  Handshake               Word
//  insn      in         insn_valid/insn_ready   insn_t: address, word, start flag
//  xref      out        xref_valid/xref_ready   xref_t: source, target, kind
//  cfg       in         cfg_we (no wait)        cfg_index selects start or limit
//
// One word is accepted per cycle while insn_ready is high. A result goes from the
// stage-one register, fed by the page memory's single read port, via the target
// add to the output register. Marks and pages are updated at the accepting edge,
// so back-to-back words need neither forwarding nor an interlock. A stalled output
// holds its word and the stage before it still takes one more word. Reset clears
// the pending marks, the section registers and the stage valid flags; the page
// memory needs no clearing, since an entry is read only after its mark is set.
`include "arm64_xref_detector_defines.svh"

module arm64_xref_detector
    import axd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        insn_valid,
    output logic        insn_ready,
    input  insn_t       insn,
    output logic        xref_valid,
    input  logic        xref_ready,
    output xref_t       xref,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    dec_t                 dec;
    pt_ctl_t              pt_ctl;
    logic [REG_COUNT-1:0] pending;
    page_t                read_page;

    logic [63:0] section_start_reg;
    logic [63:0] section_limit_reg;

    logic in_fire;
    logic data_hit;
    logic s1_enter;

    // Stage one: word accepted, page being read.
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [63:0]         s1_pc_reg;
    kind_t               s1_kind_reg;
    logic [63:0]         s1_target_reg;
    logic [OFFSET_W-1:0] s1_offset_reg;
    logic [63:0]         s1_target;

    // Stage two: output register.
    logic  s2_valid_reg;
    logic  s2_valid_next;
    xref_t s2_reg;
    logic  s2_keep;
    logic  s2_emit;
    logic  s2_free;
    logic  s1_free;

    axd_decode u_decode (
        .insn (insn),
        .dec  (dec)
    );

    // A consumer only counts when its base mark survives the start flag.
    assign data_hit = dec.is_mem && pending[dec.rn] && !insn.first_of_run;
    assign in_fire  = insn_valid && insn_ready;
    assign s1_enter = in_fire && (dec.is_call || dec.is_branch || data_hit);

    always_comb
    begin
        pt_ctl           = '0;
        pt_ctl.clear_all = in_fire && (insn.first_of_run || dec.is_call);
        pt_ctl.set_en    = in_fire && dec.is_adrp;
        pt_ctl.set_idx   = dec.rd;
        pt_ctl.set_page  = dec.mark_page;
        pt_ctl.use_en    = in_fire && data_hit;
        pt_ctl.use_idx   = dec.rn;
    end

    axd_page_table u_page_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (pt_ctl),
        .pending   (pending),
        .read_page (read_page)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_start_reg <= '0;
            section_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SECTION_START: section_start_reg <= cfg_data;
                CFG_SECTION_LIMIT: section_limit_reg <= cfg_data;
                default:           section_start_reg <= section_start_reg;
            endcase
        end
    end

    // Flow control: a suppressed data word in the output register counts as empty.
    assign s2_keep    = (s2_reg.ref_kind != KIND_DATA)
                        || (s2_reg.target_address < section_start_reg)
                        || (s2_reg.target_address >= section_limit_reg);
    assign s2_emit    = s2_valid_reg && s2_keep;
    assign s2_free    = !s2_emit || xref_ready;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign insn_ready = s1_free;

    assign s1_valid_next = s1_free ? s1_enter : s1_valid_reg;
    assign s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_enter)
        begin
            s1_pc_reg     <= insn.insn_address;
            s1_target_reg <= dec.branch_target;
            s1_offset_reg <= dec.data_offset;
            if (dec.is_call)
            begin
                s1_kind_reg <= KIND_CALL;
            end
            else if (dec.is_branch)
            begin
                s1_kind_reg <= KIND_BRANCH;
            end
            else
            begin
                s1_kind_reg <= KIND_DATA;
            end
        end
    end

    // Data targets are the stored page plus the scaled immediate.
    assign s1_target = (s1_kind_reg == KIND_DATA)
                       ? ({read_page, 12'h000} + {{(64 - OFFSET_W){1'b0}}, s1_offset_reg})
                       : s1_target_reg;

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_reg.source_address <= s1_pc_reg;
            s2_reg.target_address <= s1_target;
            s2_reg.ref_kind       <= s1_kind_reg;
        end
    end

    assign xref_valid = s2_emit;
    assign xref       = s2_reg;

    `AXD_ASSERT_NEXT(a_call_clears_marks, clk, rst_n, in_fire && dec.is_call,
        pending == '0, "marks still pending after a call")
    `AXD_ASSERT_NEXT(a_adrp_sets_mark, clk, rst_n, in_fire && dec.is_adrp,
        pending[$past(dec.rd)], "ADRP did not leave its mark")
    `AXD_ASSERT_NEXT(a_use_clears_mark, clk, rst_n, in_fire && data_hit,
        !pending[$past(dec.rn)], "consumed mark still pending")
    `AXD_ASSERT_NOW(a_data_outside, clk, rst_n,
        xref_valid && xref.ref_kind == KIND_DATA,
        xref.target_address < section_start_reg || xref.target_address >= section_limit_reg,
        "data reference inside the section was emitted")

endmodule
